// ----- sv/base64_decoder_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the base64 decoder
// Implication checks on the rising clock edge, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BASE64_DECODER_ASSERT_SVH
`define BASE64_DECODER_ASSERT_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define B64D_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("b64d assertion failed");
// next-cycle implication
`define B64D_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("b64d assertion failed");
`else
`define B64D_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define B64D_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ----- sv/b64d_pkg.sv -----
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types and constants of the base64 decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package b64d_pkg;

    localparam logic [1:0] LAST_POS = 2'd3;

    // one decoded group: up to three bytes, index of the final one, error flag
    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [1:0] last_idx;
        logic       bad;
    } t_group;

endpackage

`default_nettype wire

// ----- sv/base64_decoder.sv -----
// ----------------------------------------------------------------------------
// base64_decoder
// Standard-alphabet base64 decoder, one character per beat in, one byte out.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+----------------------------------
//  input   | in        | i_valid / o_ready  | i_character
//  output  | out       | o_valid / i_ready  | o_data_byte, o_last_of_group,
//          |           |                    | o_bad_padding
//
//  One character per cycle while o_ready; one byte beat per cycle while i_ready.
//  A group's first byte goes through the group queue and then the output stage.
//  The group queue (DEPTH records) lets the input run on while the output stalls;
//  o_ready drops only on a fourth character with the queue full.
//  Reset clears group position, pad count, queue and the output stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module base64_decoder #(
    parameter int DEPTH = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic [7:0]  i_character,
    input  wire logic        i_valid,
    output logic             o_ready,
    output logic [7:0]       o_data_byte,
    output logic             o_last_of_group,
    output logic             o_bad_padding,
    output logic             o_valid,
    input  wire logic        i_ready
);
    import b64d_pkg::*;

    logic   push;
    logic   q_ready;
    t_group front_grp;
    logic   q_valid;
    t_group q_grp;
    logic   pop;

    b64d_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_character (i_character),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .o_push      (push),
        .o_grp       (front_grp),
        .i_q_ready   (q_ready)
    );

    b64d_queue #(
        .DEPTH (DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_grp   (front_grp),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_grp   (q_grp),
        .i_pop   (pop)
    );

    b64d_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (q_valid),
        .i_grp           (q_grp),
        .o_pop           (pop),
        .o_data_byte     (o_data_byte),
        .o_last_of_group (o_last_of_group),
        .o_bad_padding   (o_bad_padding),
        .o_valid         (o_valid),
        .i_ready         (i_ready)
    );

endmodule

`default_nettype wire

// ----- sv/b64d_front.sv -----
// ----------------------------------------------------------------------------
// b64d_front
// Maps characters to sextets, counts pads, assembles one group record
// on the fourth character of each group.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "base64_decoder_assert.svh"

module b64d_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic [7:0]      i_character,
    input  wire logic            i_valid,
    output logic                 o_ready,
    output logic                 o_push,
    output b64d_pkg::t_group     o_grp,
    input  wire logic            i_q_ready
);
    import b64d_pkg::*;

    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_Z  = 8'h7A;
    localparam logic [7:0] CH_DIG_0 = 8'h30;
    localparam logic [7:0] CH_DIG_9 = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_PAD   = 8'h3D;
    localparam logic [7:0] OFS_LO   = 8'd26;
    localparam logic [7:0] OFS_DIG  = 8'd52;

    function automatic logic [5:0] sextet_of(input logic [7:0] ch);
        logic [7:0] v;
        v = 8'd0;
        if (ch inside {[CH_UP_A:CH_UP_Z]}) begin
            v = ch - CH_UP_A;
        end else if (ch inside {[CH_LO_A:CH_LO_Z]}) begin
            v = ch - CH_LO_A + OFS_LO;
        end else if (ch inside {[CH_DIG_0:CH_DIG_9]}) begin
            v = ch - CH_DIG_0 + OFS_DIG;
        end else if (ch == CH_PLUS) begin
            v = 8'd62;
        end else if (ch == CH_SLASH) begin
            v = 8'd63;
        end
        return v[5:0];
    endfunction

    logic [1:0] r_pos;
    logic [1:0] r_pad;
    logic [5:0] r_sx [3];

    logic       accept;
    logic       is_pad;
    logic [5:0] sx;
    logic [2:0] total;
    logic [5:0] sa, sb, sc;

    always_comb begin
        sx      = sextet_of(i_character);
        is_pad  = (i_character == CH_PAD);
        o_ready = (r_pos != LAST_POS) || i_q_ready;
        accept  = i_valid && o_ready;
        o_push  = i_valid && (r_pos == LAST_POS) && i_q_ready;

        total = {1'b0, r_pad} + {2'b00, is_pad};
        sa    = r_sx[0];
        sb    = r_sx[1];
        sc    = r_sx[2];

        if (total > 3'd2) begin
            o_grp.b0       = 8'd0;
            o_grp.b1       = 8'd0;
            o_grp.b2       = 8'd0;
            o_grp.last_idx = 2'd0;
            o_grp.bad      = 1'b1;
        end else begin
            o_grp.b0       = {sa, sb[5:4]};
            o_grp.b1       = {sb[3:0], sc[5:2]};
            o_grp.b2       = {sc[1:0], sx};
            o_grp.last_idx = 2'(3'd2 - total);
            o_grp.bad      = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= 2'd0;
            r_pad <= 2'd0;
        end else if (accept) begin
            if (r_pos == LAST_POS) begin
                r_pos <= 2'd0;
                r_pad <= 2'd0;
            end else begin
                r_pos <= r_pos + 2'd1;
                r_pad <= r_pad + {1'b0, is_pad};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && (r_pos != LAST_POS)) begin
            r_sx[r_pos] <= sx;
        end
    end

    `B64D_ASSERT_IMP(a_pad_le_pos, i_clk, i_rst_n, 1'b1, r_pad <= r_pos)

endmodule

`default_nettype wire

// ----- sv/b64d_queue.sv -----
// ----------------------------------------------------------------------------
// b64d_queue
// Small FIFO of group records between the front and the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "base64_decoder_assert.svh"

module b64d_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire b64d_pkg::t_group  i_grp,
    output logic                   o_ready,
    output logic                   o_valid,
    output b64d_pkg::t_group       o_grp,
    input  wire logic              i_pop
);
    import b64d_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_group             r_mem [DEPTH];
    logic [IDX_W-1:0]   r_wr;
    logic [IDX_W-1:0]   r_rd;
    logic [CNT_W-1:0]   r_count;
    logic               do_push;
    logic               do_pop;

    always_comb begin
        o_ready = (r_count != CNT_W'(DEPTH));
        o_valid = (r_count != '0);
        o_grp   = r_mem[r_rd];
        do_push = i_push && o_ready;
        do_pop  = i_pop && o_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == IDX_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == IDX_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_grp;
        end
    end

    `B64D_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(DEPTH))

endmodule

`default_nettype wire

// ----- sv/b64d_back.sv -----
// ----------------------------------------------------------------------------
// b64d_back
// Holds one group record and hands out its bytes, one beat per cycle while i_ready is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "base64_decoder_assert.svh"

module b64d_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_q_valid,
    input  wire b64d_pkg::t_group  i_grp,
    output logic                   o_pop,
    output logic [7:0]             o_data_byte,
    output logic                   o_last_of_group,
    output logic                   o_bad_padding,
    output logic                   o_valid,
    input  wire logic              i_ready
);
    import b64d_pkg::*;

    t_group     r_grp;
    logic       r_valid;
    logic [1:0] r_idx;
    logic       beat;
    logic       free;

    always_comb begin
        o_valid         = r_valid;
        o_last_of_group = (r_idx == r_grp.last_idx);
        o_bad_padding   = r_grp.bad;
        case (r_idx)
            2'd0:    o_data_byte = r_grp.b0;
            2'd1:    o_data_byte = r_grp.b1;
            default: o_data_byte = r_grp.b2;
        endcase
        beat  = r_valid && i_ready;
        free  = !r_valid || (beat && o_last_of_group);
        o_pop = free && i_q_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (free) begin
            r_valid <= i_q_valid;
            r_idx   <= 2'd0;
        end else if (beat) begin
            r_idx   <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_grp <= i_grp;
        end
    end

    `B64D_ASSERT_IMP(a_bad_single, i_clk, i_rst_n, o_valid && o_bad_padding, o_last_of_group && (o_data_byte == 8'd0))
    `B64D_ASSERT_NXT(a_group_cont, i_clk, i_rst_n, o_valid && i_ready && !o_last_of_group, o_valid && (r_idx != 2'd0))

endmodule

`default_nettype wire
